// File: hdl/hypergraph_net_cut_connectivity_tracker_assert.svh
// assertion macros for the net cut and connectivity tracker
// no dependencies; included by the top level only
`ifndef HYPERGRAPH_NET_CUT_CONNECTIVITY_TRACKER_ASSERT_SVH
`define HYPERGRAPH_NET_CUT_CONNECTIVITY_TRACKER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HNCT_ASSERT_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HNCT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HNCT_ASSERT_RST(label, clk, rst, prop, msg)
`define HNCT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: hdl/hnct_pkg.sv
// shared types and widths of the net cut and connectivity tracker
// no dependencies
`default_nettype none

package hnct_pkg;

  localparam int BLOCK_W = 4;
  localparam int NET_W   = 13;
  localparam int WEIGHT_W = 16;
  localparam int CUT_W   = 40;
  localparam int CONN_W  = 44;
  localparam int PINS_W  = 32;

  typedef struct packed {
    logic [BLOCK_W-1:0]  part_block;
    logic [NET_W-1:0]    net_index;
    logic [WEIGHT_W-1:0] net_weight;
  } pin_t;

  typedef struct packed {
    logic [CUT_W-1:0]  cut_total;
    logic [CONN_W-1:0] connectivity_total;
    logic [PINS_W-1:0] pins_seen;
  } totals_t;

endpackage

`default_nettype wire

// File: hdl/hypergraph_net_cut_connectivity_tracker.sv
// top level of the hypergraph net cut and connectivity tracker
// depends on hnct_pkg and hypergraph_net_cut_connectivity_tracker_assert.svh
`default_nettype none

// Streams pins (block of the owning node, one-based net index, net weight) and
// returns, for every pin, the running cut total, connectivity total and pin
// count, all saturating. Per net, one memory word holds the mask of blocks
// that have touched it; the net status (empty, single block, cut) follows from
// that mask: empty when no bit is set, single when exactly one is, cut when
// more. Throughput is one pin per cycle while the output is not stalled. The
// read stage reads the net's mask word from the synchronous memory; the merge
// stage merges the block bit, writes the word back and updates
// the totals into the result register. A pin on the same net as the one right
// before it takes the written-back mask through a forwarding register, so
// back-to-back pins on one net need no bubble. The result register sits in
// front of the output, so a new pin is taken while a result waits as long as
// the merge stage is empty. After reset the block runs a clearing pass over
// every word of the mask memory, during which pin_ready is low.
// Pins with a net index of zero or above NET_COUNT, or a block at or above
// BLOCK_COUNT, only count in pins_seen.
module hypergraph_net_cut_connectivity_tracker #(
  parameter int NET_COUNT   = 4096,
  parameter int BLOCK_COUNT = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pin_valid,
  output logic                  pin_ready,
  input  wire hnct_pkg::pin_t   pin,
  output logic                  total_valid,
  input  wire logic             total_ready,
  output hnct_pkg::totals_t     totals
);

  // mask width: the block field cannot name more than 2**BLOCK_W blocks
  localparam int MAX_BLOCKS = 1 << hnct_pkg::BLOCK_W;
  localparam int MASK_W = (BLOCK_COUNT < MAX_BLOCKS) ? BLOCK_COUNT : MAX_BLOCKS;
  localparam int NET_AW = $clog2(NET_COUNT);
  localparam int RANGE_W0 = $clog2(NET_COUNT + 1);
  localparam int CMP_W = (RANGE_W0 > hnct_pkg::NET_W) ? RANGE_W0 : hnct_pkg::NET_W;

  // ---------------------------------------------------------------------------
  // clearing pass after reset
  // ---------------------------------------------------------------------------
  logic              clearing;
  logic [NET_AW-1:0] clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + 1'b1;
      if (clear_addr == NET_AW'(NET_COUNT - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // read stage: range checks, slot and block bit of the incoming pin
  // ---------------------------------------------------------------------------
  logic              pin_xfer;
  logic [CMP_W-1:0]  net_wide;
  logic [CMP_W-1:0]  slot_wide;
  logic              net_ok;
  logic              block_ok;
  logic [NET_AW-1:0] rd_slot;
  logic [MASK_W-1:0] rd_bit;

  always_comb begin
    net_wide  = CMP_W'(pin.net_index);
    slot_wide = net_wide - CMP_W'(1);
    net_ok    = (net_wide != '0) && (net_wide <= CMP_W'(NET_COUNT));
    block_ok  = 32'(pin.part_block) < BLOCK_COUNT;
    rd_slot   = slot_wide[NET_AW-1:0];
    rd_bit    = MASK_W'(1) << pin.part_block;
  end

  // ---------------------------------------------------------------------------
  // merge stage registers
  // ---------------------------------------------------------------------------
  logic                         s1_valid;
  logic                         s1_hit;
  logic [NET_AW-1:0]            s1_slot;
  logic [MASK_W-1:0]            s1_bit;
  logic [hnct_pkg::WEIGHT_W-1:0] s1_weight;
  logic                         s1_advance;

  // memory and forwarding
  logic [MASK_W-1:0] mask_mem [NET_COUNT];
  logic [MASK_W-1:0] rd_data;
  logic              fwd;
  logic [MASK_W-1:0] fwd_data;
  logic              mem_we;
  logic [NET_AW-1:0] mem_waddr;
  logic [MASK_W-1:0] mem_wdata;

  // running totals double as the result payload: they only change when a
  // result is loaded, so they hold while the result waits
  logic [hnct_pkg::CUT_W-1:0]  cut_sum;
  logic [hnct_pkg::CONN_W-1:0] connectivity_sum;
  logic [hnct_pkg::PINS_W-1:0] pin_counter;

  assign s1_advance = s1_valid && (!total_valid || total_ready);
  assign pin_ready  = !clearing && (!s1_valid || s1_advance);
  assign pin_xfer   = pin_valid && pin_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pin_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pin_xfer) begin
      s1_hit    <= net_ok && block_ok;
      s1_slot   <= rd_slot;
      s1_bit    <= rd_bit;
      s1_weight <= pin.net_weight;
      // write-back of the pin ahead lands in the same cycle as this read
      fwd       <= mem_we && (mem_waddr == rd_slot);
      fwd_data  <= mem_wdata;
    end
  end

  // synchronous mask memory, one read and one write port
  always_ff @(posedge clk) begin
    if (pin_xfer) begin
      rd_data <= mask_mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mask_mem[mem_waddr] <= mem_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // merge: status from the mask, block bit in, totals up
  // ---------------------------------------------------------------------------
  logic [MASK_W-1:0] cur_mask;
  logic              bit_fresh;
  logic              net_touched;
  logic              net_single;
  logic              cut_add;
  logic              conn_add;
  logic [hnct_pkg::CUT_W:0]  cut_inc;
  logic [hnct_pkg::CONN_W:0] conn_inc;
  logic [hnct_pkg::CUT_W-1:0]  cut_sum_next;
  logic [hnct_pkg::CONN_W-1:0] connectivity_sum_next;

  always_comb begin
    cur_mask    = fwd ? fwd_data : rd_data;
    bit_fresh   = (cur_mask & s1_bit) == '0;
    net_touched = cur_mask != '0;
    // exactly one block so far: the mask has a single bit set
    net_single = net_touched && ((cur_mask & (cur_mask - MASK_W'(1))) == '0);
    cut_add    = s1_hit && bit_fresh && net_single;
    conn_add   = s1_hit && bit_fresh && net_touched;

    cut_inc  = {1'b0, cut_sum} + (hnct_pkg::CUT_W + 1)'(s1_weight);
    conn_inc = {1'b0, connectivity_sum} + (hnct_pkg::CONN_W + 1)'(s1_weight);

    cut_sum_next = cut_sum;
    if (cut_add) begin
      cut_sum_next = cut_inc[hnct_pkg::CUT_W] ? '1 : cut_inc[hnct_pkg::CUT_W-1:0];
    end
    connectivity_sum_next = connectivity_sum;
    if (conn_add) begin
      connectivity_sum_next = conn_inc[hnct_pkg::CONN_W] ? '1
                                                         : conn_inc[hnct_pkg::CONN_W-1:0];
    end

    // write port: clearing pass first, then merge write-back
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_advance && s1_hit;
      mem_waddr = s1_slot;
      mem_wdata = cur_mask | s1_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cut_sum          <= '0;
      connectivity_sum <= '0;
      pin_counter      <= '0;
    end else if (s1_advance) begin
      cut_sum          <= cut_sum_next;
      connectivity_sum <= connectivity_sum_next;
      if (pin_counter != '1) begin
        pin_counter <= pin_counter + 1'b1;
      end
    end
  end

  // result register valid: set when a result loads, cleared on its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      total_valid <= 1'b0;
    end else if (s1_advance) begin
      total_valid <= 1'b1;
    end else if (total_ready) begin
      total_valid <= 1'b0;
    end
  end

  always_comb begin
    totals.cut_total          = cut_sum;
    totals.connectivity_total = connectivity_sum;
    totals.pins_seen          = pin_counter;
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
`include "hypergraph_net_cut_connectivity_tracker_assert.svh"

  `HNCT_ASSERT_RST(a_no_merge_while_clearing, clk, rst, clearing |-> !s1_valid && !pin_ready, "pin in flight during clearing pass")
  `HNCT_ASSERT_RST(a_cut_within_conn, clk, rst, {4'b0, cut_sum} <= connectivity_sum, "cut total above connectivity total")
  `HNCT_ASSERT_RST(a_pin_count_step, clk, rst, s1_advance && (pin_counter != '1) |=> pin_counter == $past(pin_counter) + 1'b1, "pin count did not step with a result")
  `HNCT_ASSERT_RST(a_totals_hold_stalled, clk, rst, total_valid && !total_ready |=> $stable(cut_sum) && $stable(connectivity_sum), "totals moved while result stalled")

endmodule

`default_nettype wire
